### rtl/dhcp_lease_allocator_assert.svh
// Assertion macros for the DHCP lease allocator.
// No dependencies; included by files that carry concurrent checks.
`ifndef DHCP_LEASE_ALLOCATOR_ASSERT_SVH
`define DHCP_LEASE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DLA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dla_pkg.sv
// Shared types and constants for the DHCP lease allocator.
// No dependencies.
package dla_pkg;
	localparam int LEASE_SLOTS   = 16;
	localparam int POOL_SCAN_MAX = 256;
	localparam int SLOT_W        = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
	localparam int CNT_W         = $clog2(LEASE_SLOTS + 1);

	localparam logic [2:0] FN_DISCOVER = 3'd0;
	localparam logic [2:0] FN_REQUEST  = 3'd1;
	localparam logic [2:0] FN_OTHER    = 3'd2;
	localparam logic [2:0] FN_REAP     = 3'd3;
	localparam logic [2:0] FN_CLEAR    = 3'd4;

	localparam logic [2:0] ST_OFFER   = 3'd0;
	localparam logic [2:0] ST_ACK     = 3'd1;
	localparam logic [2:0] ST_IGNORED = 3'd2;
	localparam logic [2:0] ST_NOFREE  = 3'd3;
	localparam logic [2:0] ST_MAINT   = 3'd4;

	localparam logic [2:0] REG_IFACE_IP   = 3'd0;
	localparam logic [2:0] REG_POOL_START = 3'd1;
	localparam logic [2:0] REG_POOL_END   = 3'd2;
	localparam logic [2:0] REG_LEASE_SECS = 3'd3;
	localparam logic [2:0] REG_FILTER_MAC = 3'd4;
	localparam logic [2:0] REG_FILTER_EN  = 3'd5;

	typedef struct packed {
		logic [2:0]  func;
		logic [47:0] client_mac;
		logic [31:0] requested_ip;
		logic [31:0] server_id;
		logic [31:0] now_secs;
	} dla_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] assigned_ip;
		logic [4:0]  removed_count;
	} dla_out_t;

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_EMIT} dla_state_t;
	typedef enum logic [1:0] {IPS_REQ, IPS_CUR, IPS_CAND} dla_ipsrc_t;

	typedef struct packed {
		logic       idle;
		logic       load_item;
		logic       maint;
		logic       scan_init;
		logic       scan_step;
		logic       rec_en;
		dla_ipsrc_t ip_src;
		logic       res_load;
		logic [2:0] res_status;
		logic       emit;
	} dla_cmd_t;

	typedef struct packed {
		logic is_maint;
		logic is_disc;
		logic is_req;
		logic filtered;
		logic sid_bad;
		logic req_zero;
		logic cur_live;
		logic tgt_ok;
		logic pool_ok;
		logic cand_free;
		logic cand_last;
		logic out_busy;
	} dla_sts_t;
endpackage

### rtl/dhcp_lease_allocator.sv
// DHCP lease allocator. An input beat is registered in the idle state and looked up in the
// lookup state; when a new pool address is needed, the scan state tries one address per
// step (up to POOL_SCAN_MAX). Items are taken one at a time; a stalled result
// holds the next item in the emit state. The next item may be accepted while a result
// waits in the output register. Reset: lease table empty, registers at defaults.
`include "dhcp_lease_allocator_assert.svh"
module dhcp_lease_allocator import dla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  dla_in_t     req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output dla_out_t    rsp_data
);
	dla_cmd_t cmd;
	dla_sts_t sts;

	dla_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .sts(sts), .cmd(cmd)
	);

	dla_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_data(req_data), .cmd(cmd), .rsp_stall(rsp_stall),
		.sts(sts), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
	);

	assign req_stall = !cmd.idle;

	`DLA_ASSERT_NXT(a_busy_after_beat, clk, arst_n, req_valid && !req_stall, req_stall)
	`DLA_ASSERT_IMP(a_ip_zero, clk, arst_n, rsp_valid && rsp_data.status != ST_OFFER && rsp_data.status != ST_ACK, rsp_data.assigned_ip == '0)
	`DLA_ASSERT_IMP(a_rm_zero, clk, arst_n, rsp_valid && rsp_data.status != ST_MAINT, rsp_data.removed_count == '0)
endmodule

### rtl/dla_dp.sv
// Datapath: config registers, lease table, pool scan and result registers.
// Depends on dla_pkg.
module dla_dp import dla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  dla_in_t     req_data,
	input  dla_cmd_t    cmd,
	input  logic        rsp_stall,
	output dla_sts_t    sts,
	output logic        rsp_valid,
	output dla_out_t    rsp_data
);
	logic [31:0] iface_q, pstart_q, pend_q, lsecs_q;
	logic [47:0] fmac_q;
	logic        fen_q;
	dla_in_t     item_q;
	logic [31:0] cand_q;
	logic [LEASE_SLOTS-1:0] valid_q;
	logic [47:0] mac_q [LEASE_SLOTS];
	logic [31:0] ip_q  [LEASE_SLOTS];
	logic [31:0] exp_q [LEASE_SLOTS];
	dla_out_t    res_q, out_q;
	logic        out_valid_q;

	logic [LEASE_SLOTS-1:0] hit, rm_mask;
	logic [SLOT_W-1:0] cur_idx, free_idx, tgt_idx;
	logic        has_cur, has_free, held;
	logic [32:0] exp_sum;
	logic [31:0] exp_new, span, src_ip;
	logic [CNT_W-1:0] rm_cnt;
	logic [4:0]  rm_sat;

	always_comb begin
		cur_idx  = '0;
		free_idx = '0;
		held     = 1'b0;
		rm_cnt   = '0;
		for (int i = LEASE_SLOTS - 1; i >= 0; i--) begin
			hit[i] = valid_q[i] && (mac_q[i] == item_q.client_mac);
			if (hit[i]) cur_idx = SLOT_W'(i);
			if (!valid_q[i]) free_idx = SLOT_W'(i);
			rm_mask[i] = valid_q[i] &&
				(item_q.func == FN_CLEAR || exp_q[i] <= item_q.now_secs);
		end
		for (int i = 0; i < LEASE_SLOTS; i++) begin
			if (valid_q[i] && ip_q[i] == cand_q && exp_q[i] > item_q.now_secs) held = 1'b1;
			rm_cnt = rm_cnt + CNT_W'(rm_mask[i]);
		end
	end

	assign has_cur  = |hit;
	assign has_free = ~&valid_q;
	assign tgt_idx  = has_cur ? cur_idx : free_idx;
	assign exp_sum  = {1'b0, item_q.now_secs} + {1'b0, lsecs_q};
	assign exp_new  = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
	assign span     = pend_q - pstart_q;
	assign rm_sat   = (32'(rm_cnt) > 32'd31) ? 5'd31 : 5'(rm_cnt);

	always_comb begin
		case (cmd.ip_src)
			IPS_REQ: src_ip = item_q.requested_ip;
			IPS_CUR: src_ip = ip_q[cur_idx];
			default: src_ip = cand_q;
		endcase
	end

	always_comb begin
		sts.is_maint  = item_q.func == FN_REAP || item_q.func == FN_CLEAR;
		sts.is_disc   = item_q.func == FN_DISCOVER;
		sts.is_req    = item_q.func == FN_REQUEST;
		sts.filtered  = fen_q && item_q.client_mac != fmac_q;
		sts.sid_bad   = item_q.server_id != '0 && item_q.server_id != iface_q;
		sts.req_zero  = item_q.requested_ip == '0;
		sts.cur_live  = has_cur && exp_q[cur_idx] > item_q.now_secs;
		sts.tgt_ok    = has_cur || has_free;
		sts.pool_ok   = pend_q >= pstart_q && span < 32'(POOL_SCAN_MAX);
		sts.cand_free = cand_q != '0 && !held;
		sts.cand_last = cand_q == pend_q;
		sts.out_busy  = out_valid_q && rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iface_q  <= '0;
			pstart_q <= '0;
			pend_q   <= '0;
			lsecs_q  <= 32'd3600;
			fmac_q   <= '0;
			fen_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IFACE_IP:   iface_q  <= cfg_data[31:0];
				REG_POOL_START: pstart_q <= cfg_data[31:0];
				REG_POOL_END:   pend_q   <= cfg_data[31:0];
				REG_LEASE_SECS: lsecs_q  <= cfg_data[31:0];
				REG_FILTER_MAC: fmac_q   <= cfg_data;
				REG_FILTER_EN:  fen_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.maint) begin
			valid_q <= valid_q & ~rm_mask;
		end else if (cmd.rec_en) begin
			valid_q[tgt_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_en) begin
			mac_q[tgt_idx] <= item_q.client_mac;
			ip_q[tgt_idx]  <= src_ip;
			exp_q[tgt_idx] <= exp_new;
		end
		if (cmd.load_item) item_q <= req_data;
		if (cmd.scan_init) cand_q <= pstart_q;
		else if (cmd.scan_step) cand_q <= cand_q + 32'd1;
		if (cmd.res_load) begin
			res_q.status        <= cmd.res_status;
			res_q.assigned_ip   <= (cmd.res_status == ST_OFFER || cmd.res_status == ST_ACK)
				? src_ip : '0;
			res_q.removed_count <= (cmd.res_status == ST_MAINT) ? rm_sat : 5'd0;
		end
		if (cmd.emit) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;
endmodule

### rtl/dla_ctrl.sv
// Controller state machine: sequences lookup, pool scan and result beat.
// Depends on dla_pkg.
module dla_ctrl import dla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  dla_sts_t sts,
	output dla_cmd_t cmd
);
	dla_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_nx = S_LOOK;
			S_LOOK: begin
				if (!sts.is_maint && !sts.filtered && !sts.cur_live && sts.tgt_ok
				    && sts.pool_ok && (sts.is_disc || (sts.is_req && !sts.sid_bad
				    && sts.req_zero)))
					state_nx = S_SCAN;
				else
					state_nx = S_EMIT;
			end
			S_SCAN: if (sts.cand_free || sts.cand_last) state_nx = S_EMIT;
			S_EMIT: if (!sts.out_busy) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.ip_src = IPS_CAND;
		cmd.res_status = ST_IGNORED;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				cmd.load_item = req_valid;
			end
			S_LOOK: begin
				cmd.res_load = 1'b1;
				if (sts.is_maint) begin
					cmd.maint = 1'b1;
					cmd.res_status = ST_MAINT;
				end else if (sts.filtered || !(sts.is_disc || sts.is_req)
				             || (sts.is_req && sts.sid_bad)) begin
					cmd.res_status = ST_IGNORED;
				end else if (sts.is_req && !sts.req_zero) begin
					cmd.ip_src = IPS_REQ;
					cmd.rec_en = sts.tgt_ok;
					cmd.res_status = sts.tgt_ok ? ST_ACK : ST_NOFREE;
				end else if (sts.cur_live) begin
					// live lease: discover offers it, request renews it
					cmd.ip_src = IPS_CUR;
					cmd.rec_en = sts.is_req;
					cmd.res_status = sts.is_req ? ST_ACK : ST_OFFER;
				end else if (!sts.tgt_ok || !sts.pool_ok) begin
					cmd.res_status = ST_NOFREE;
				end else begin
					cmd.res_load = 1'b0;
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				if (sts.cand_free) begin
					cmd.rec_en = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_status = sts.is_disc ? ST_OFFER : ST_ACK;
				end else if (sts.cand_last) begin
					cmd.res_load = 1'b1;
					cmd.res_status = ST_NOFREE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_EMIT: cmd.emit = !sts.out_busy;
			default: ;
		endcase
	end
endmodule

### sim/dhcp_lease_allocator_tb.sv
// Testbench for the DHCP lease allocator: directed and random messages, reap and clear
// events, checked beat by beat against a behavioral lease table kept in a scoreboard class.
// Depends on dla_pkg and the dhcp_lease_allocator RTL.
module dhcp_lease_allocator_tb;
	import dla_pkg::*;

	class lease_board;
		logic [31:0] iface_ip, pool_start, pool_end, lease_secs;
		logic [47:0] filter_mac;
		logic        filter_en;
		bit          live[LEASE_SLOTS];
		logic [47:0] mac_tab[LEASE_SLOTS];
		logic [31:0] ip_tab[LEASE_SLOTS];
		logic [31:0] exp_tab[LEASE_SLOTS];
		dla_out_t    pending[$];
		int          errors;

		function new();
			iface_ip = 0; pool_start = 0; pool_end = 0; lease_secs = 3600;
			filter_mac = 0; filter_en = 0; errors = 0;
			foreach (live[i]) live[i] = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [47:0] v);
			case (idx)
				REG_IFACE_IP:   iface_ip = v[31:0];
				REG_POOL_START: pool_start = v[31:0];
				REG_POOL_END:   pool_end = v[31:0];
				REG_LEASE_SECS: lease_secs = v[31:0];
				REG_FILTER_MAC: filter_mac = v;
				REG_FILTER_EN:  filter_en = v[0];
				default: ;
			endcase
		endfunction

		function int slot_of(logic [47:0] mac);
			for (int i = 0; i < LEASE_SLOTS; i++)
				if (live[i] && mac_tab[i] == mac) return i;
			return -1;
		endfunction

		function int dest_slot(logic [47:0] mac);
			int s;
			s = slot_of(mac);
			if (s >= 0) return s;
			for (int i = 0; i < LEASE_SLOTS; i++)
				if (!live[i]) return i;
			return -1;
		endfunction

		function bit addr_taken(logic [31:0] ip, logic [31:0] now);
			for (int i = 0; i < LEASE_SLOTS; i++)
				if (live[i] && ip_tab[i] == ip && exp_tab[i] > now) return 1;
			return 0;
		endfunction

		function void store(int s, logic [47:0] mac, logic [31:0] ip, logic [31:0] now);
			logic [32:0] e;
			e = {1'b0, now} + {1'b0, lease_secs};
			live[s] = 1; mac_tab[s] = mac; ip_tab[s] = ip;
			exp_tab[s] = e[32] ? 32'hFFFF_FFFF : e[31:0];
		endfunction

		function logic [31:0] pick_addr(logic [47:0] mac, logic [31:0] now);
			int cur, s;
			logic [32:0] cnt;
			logic [31:0] c;
			cur = slot_of(mac);
			if (cur >= 0 && exp_tab[cur] > now) return ip_tab[cur];
			s = dest_slot(mac);
			if (s < 0 || pool_end < pool_start) return 0;
			cnt = {1'b0, pool_end} - {1'b0, pool_start} + 1;
			if (cnt > POOL_SCAN_MAX) return 0;
			for (int k = 0; k < cnt; k++) begin
				c = pool_start + k;
				if (c != 0 && !addr_taken(c, now)) begin
					store(s, mac, c, now);
					return c;
				end
			end
			return 0;
		endfunction

		function void note_input(dla_in_t it);
			dla_out_t r;
			int n, s;
			r = '{ST_IGNORED, 32'd0, 5'd0};
			if (it.func == FN_REAP || it.func == FN_CLEAR) begin
				n = 0;
				for (int i = 0; i < LEASE_SLOTS; i++)
					if (live[i] && (it.func == FN_CLEAR || exp_tab[i] <= it.now_secs)) begin
						live[i] = 0; n++;
					end
				r.status = ST_MAINT;
				r.removed_count = (n > 31) ? 5'd31 : n[4:0];
			end else if (filter_en && it.client_mac != filter_mac) begin
				r.status = ST_IGNORED;
			end else if (it.func == FN_DISCOVER) begin
				r.assigned_ip = pick_addr(it.client_mac, it.now_secs);
				r.status = (r.assigned_ip != 0) ? ST_OFFER : ST_NOFREE;
			end else if (it.func == FN_REQUEST) begin
				if (it.server_id != 0 && it.server_id != iface_ip) begin
					r.status = ST_IGNORED;
				end else begin
					r.assigned_ip = (it.requested_ip != 0) ? it.requested_ip
						: pick_addr(it.client_mac, it.now_secs);
					s = (r.assigned_ip != 0) ? dest_slot(it.client_mac) : -1;
					if (s < 0) begin
						r.assigned_ip = 0;
						r.status = ST_NOFREE;
					end else begin
						store(s, it.client_mac, r.assigned_ip, it.now_secs);
						r.status = ST_ACK;
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(dla_out_t got);
			dla_out_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
				errors++;
			end
			if (got.assigned_ip !== e.assigned_ip) begin
				$display("%0t: assigned_ip exp %h got %h", $realtime, e.assigned_ip,
					got.assigned_ip);
				errors++;
			end
			if (got.removed_count !== e.removed_count) begin
				$display("%0t: removed_count exp %0d got %0d", $realtime, e.removed_count,
					got.removed_count);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        req_valid = 0;
	logic        req_stall;
	dla_in_t     req_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	dla_out_t    rsp_data;

	lease_board board = new();
	longint cycles = 0;
	bit     hold_rx = 0;
	bit     quiet = 0;
	logic [47:0] mac_set[8];
	logic [31:0] clock_now = 100;

	dhcp_lease_allocator u_top (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2_000_000) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) board.check_result(rsp_data);
		if (arst_n && req_valid && !req_stall) board.note_input(req_data);
	end

	// receiver: random stalls, long hold-off on request
	always @(negedge clk) begin
		if (hold_rx) rsp_stall <= 1;
		else if (quiet) rsp_stall <= 0;
		else if ($urandom_range(0, 99) < 25) rsp_stall <= 1;
		else if ($urandom_range(0, 99) < 3) rsp_stall <= 1;
		else rsp_stall <= 0;
	end

	// valid goes low between beats
	task automatic gap();
		int g;
		g = quiet ? 1 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
			: $urandom_range(1, 3));
		repeat (g) @(negedge clk);
	endtask

	task automatic send(dla_in_t it);
		req_valid <= 1;
		req_data <= it;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		req_valid <= 0;
		gap();
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] v);
		while (board.pending.size() != 0) @(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		board.set_reg(idx, v);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic dla_in_t msg(logic [2:0] f, logic [47:0] m, logic [31:0] rq,
		logic [31:0] sid, logic [31:0] now);
		dla_in_t it;
		it.func = f; it.client_mac = m; it.requested_ip = rq;
		it.server_id = sid; it.now_secs = now;
		return it;
	endfunction

	function automatic dla_in_t rand_item();
		dla_in_t it;
		int r;
		r = $urandom_range(0, 99);
		clock_now += $urandom_range(0, 3) == 0 ? $urandom_range(0, 500) : 0;
		it.client_mac = ($urandom_range(0, 9) < 8) ? mac_set[$urandom_range(0, 7)]
			: 48'({$urandom, $urandom});
		it.requested_ip = 0;
		it.server_id = 0;
		it.now_secs = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
		if (r < 40) it.func = FN_DISCOVER;
		else if (r < 78) begin
			it.func = FN_REQUEST;
			if ($urandom_range(0, 1)) it.requested_ip = board.pool_start + $urandom_range(0, 20);
			if ($urandom_range(0, 3) == 0) it.requested_ip = $urandom;
			case ($urandom_range(0, 3))
				0: it.server_id = board.iface_ip;
				1: it.server_id = $urandom;
				default: it.server_id = 0;
			endcase
		end else if (r < 86) it.func = FN_REAP;
		else if (r < 90) it.func = FN_CLEAR;
		else it.func = 3'($urandom_range(2, 7));
		if (it.func == FN_OTHER)
			it.func = $urandom_range(0, 1) ? FN_OTHER : 3'($urandom_range(5, 7));
		return it;
	endfunction

	task automatic random_phase(int n);
		repeat (n) send(rand_item());
	endtask

	initial begin
		foreach (mac_set[i]) mac_set[i] = 48'({$urandom, $urandom});
		mac_set[0] = 48'hFFFF_FFFF_FFFF;
		mac_set[1] = 48'h0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset defaults give pool 0..0, so the only address is zero
		send(msg(FN_DISCOVER, mac_set[2], 0, 0, 10));
		write_reg(REG_IFACE_IP, 48'hC0A8_0001);
		write_reg(REG_POOL_START, 48'h0);
		write_reg(REG_POOL_END, 48'h3);
		write_reg(REG_LEASE_SECS, 48'd100);
		send(msg(FN_DISCOVER, mac_set[0], 0, 0, 10));
		send(msg(FN_DISCOVER, mac_set[0], 0, 0, 20));
		send(msg(FN_DISCOVER, mac_set[1], 0, 0, 20));
		send(msg(FN_REQUEST, mac_set[1], 0, 32'hC0A8_0001, 20));
		send(msg(FN_REQUEST, mac_set[2], 0, 32'h0A00_0009, 20));
		send(msg(FN_REQUEST, mac_set[2], 32'hFFFF_FFFF, 0, 20));
		send(msg(FN_DISCOVER, mac_set[3], 0, 0, 20));
		send(msg(FN_DISCOVER, mac_set[4], 0, 0, 200));
		send(msg(FN_OTHER, mac_set[4], 0, 0, 200));
		send(msg(3'd7, mac_set[4], 0, 0, 200));
		send(msg(FN_REAP, 0, 0, 0, 200));
		send(msg(FN_REAP, 0, 0, 0, 32'hFFFF_FFFF));
		// fill the table with requests, then overflow it
		for (int i = 0; i < LEASE_SLOTS + 1; i++)
			send(msg(FN_REQUEST, 48'h100 + i, 32'h10 + i, 0, 300));
		drain();
		write_reg(REG_LEASE_SECS, 48'hFFFF_FFFF);
		write_reg(REG_FILTER_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_FILTER_EN, 48'h1);
		send(msg(FN_DISCOVER, mac_set[3], 0, 0, 400));
		send(msg(FN_CLEAR, mac_set[3], 0, 0, 400));
		send(msg(FN_DISCOVER, mac_set[0], 0, 0, 32'hFFFF_FFF0));
		drain();
		write_reg(REG_FILTER_EN, 48'h0);
		// reversed pool, then a pool exactly at the scan limit, then one over it
		write_reg(REG_POOL_START, 48'h10);
		write_reg(REG_POOL_END, 48'hF);
		send(msg(FN_DISCOVER, mac_set[5], 0, 0, 500));
		drain();
		write_reg(REG_POOL_START, 48'hFFFF_FF00);
		write_reg(REG_POOL_END, 48'hFFFF_FFFF);
		send(msg(FN_DISCOVER, mac_set[6], 0, 0, 500));
		send(msg(FN_CLEAR, 0, 0, 0, 500));
		drain();
		write_reg(REG_POOL_START, 48'hFFFF_FEFF);
		send(msg(FN_DISCOVER, mac_set[6], 0, 0, 500));
		drain();

		// random phases across settings
		write_reg(REG_POOL_START, 48'h0A00_0001);
		write_reg(REG_POOL_END, 48'h0A00_0006);
		write_reg(REG_LEASE_SECS, 48'd300);
		random_phase(160);
		drain();
		write_reg(REG_IFACE_IP, 48'hFFFF_FFFF);
		write_reg(REG_POOL_START, 48'h0);
		write_reg(REG_POOL_END, 48'd40);
		write_reg(REG_LEASE_SECS, 48'd0);
		random_phase(110);
		drain();
		write_reg(REG_LEASE_SECS, 48'd2000);
		write_reg(REG_FILTER_MAC, mac_set[3]);
		write_reg(REG_FILTER_EN, 48'h1);
		random_phase(80);
		drain();
		write_reg(REG_FILTER_EN, 48'h0);
		write_reg(REG_IFACE_IP, 48'h0);
		write_reg(REG_POOL_START, 48'hC0A8_0000);
		write_reg(REG_POOL_END, 48'hC0A8_00FF);
		// receiver holds off long while items keep coming
		fork
			begin
				hold_rx = 1;
				repeat (400) @(negedge clk);
				hold_rx = 0;
			end
			random_phase(20);
		join
		random_phase(120);
		quiet = 1;
		random_phase(60);
		quiet = 0;
		random_phase(60);

		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
